### design/wes_pkg.sv
package wes_pkg;

	localparam int DEF_MAX_POINTS  = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int KIND_W     = 2;
	localparam int PTS_W      = 11;
	localparam int CRS_W      = 16;
	localparam int CRS_FRAC   = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MIN_POINTS = 3;

	localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(1024);
	localparam logic [CRS_W-1:0] CRS_RESET = CRS_W'(16384);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_READ    = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINTS  = 2'd0,
		REG_COURANT = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	// sweep control into the stencil datapath, aligned with memory read data
	typedef struct packed {
		logic data_v;
		logic point_v;
		logic first_pt;
	} dp_ctl_t;

endpackage

### design/wes_if.sv
interface wes_item_if import wes_pkg::*; #(
	parameter int IW = 10,
	parameter int SW = 16
);
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IW-1:0]     point_index;
	logic signed [SW-1:0] point_value;

	modport source(output valid, kind, point_index, point_value, input ready);
	modport sink(input valid, kind, point_index, point_value, output ready);
endinterface

interface wes_result_if #(
	parameter int IW = 10,
	parameter int SW = 16
);
	logic              valid;
	logic              ready;
	logic [IW-1:0]     read_index;
	logic signed [SW-1:0] read_value;

	modport source(output valid, read_index, read_value, input ready);
	modport sink(input valid, read_index, read_value, output ready);
endinterface

interface wes_cfg_if import wes_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/wes_field_mem.sv
module wes_field_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int SW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [SW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [SW-1:0] rdata
);

	logic [SW-1:0] mem_q [DEPTH];
	logic [SW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/wes_stencil_dp.sv
module wes_stencil_dp import wes_pkg::*; #(
	parameter int IW = 10,
	parameter int SW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_ctl_t              ctl,
	input  logic [CRS_W-1:0]     c2,
	input  logic signed [SW-1:0] cur_rdata,
	input  logic signed [SW-1:0] past_rdata,
	output logic                 wr_v,
	output logic [IW-1:0]        wr_idx,
	output logic [SW-1:0]        wr_data,
	output logic                 busy
);

	localparam int LW = SW + 2;
	localparam int PW = CRS_W + 1 + LW;
	localparam int XW = PW + 1;
	localparam logic signed [XW-1:0] RND    = XW'(64'sd1 <<< (CRS_FRAC - 1));
	localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

	logic signed [SW-1:0] win_l_q, win_c_q;

	logic                 v_s2, v_s3, v_s4;
	logic [IW-1:0]        idx_s2, idx_s3, idx_s4;
	logic signed [LW-1:0] lap_s2, base_s2, base_s3;
	logic signed [PW-1:0] prod_s3;
	logic [SW-1:0]        data_s4;

	logic signed [XW-1:0] term, sum;
	logic signed [SW-1:0] sat;

	always_comb begin
		term = (XW'(prod_s3) + RND) >>> CRS_FRAC;
		sum  = term + XW'(base_s3);
		if (sum > SAT_HI) begin
			sat = SW'(SAT_HI);
		end else if (sum < SAT_LO) begin
			sat = SW'(SAT_LO);
		end else begin
			sat = SW'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= ctl.point_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.data_v) begin
			win_l_q <= win_c_q;
			win_c_q <= cur_rdata;
		end
		if (ctl.point_v) begin
			// right is the word arriving now
			lap_s2  <= LW'(cur_rdata) + LW'(win_l_q) - (LW'(win_c_q) <<< 1);
			base_s2 <= (LW'(win_c_q) <<< 1) - LW'(past_rdata);
			idx_s2  <= ctl.first_pt ? '0 : idx_s2 + 1'b1;
		end
		prod_s3 <= $signed({1'b0, c2}) * lap_s2;
		base_s3 <= base_s2;
		idx_s3  <= idx_s2;
		data_s4 <= sat;
		idx_s4  <= idx_s3;
	end

	assign wr_v    = v_s4;
	assign wr_idx  = idx_s4;
	assign wr_data = data_s4;
	assign busy    = v_s2 | v_s3 | v_s4;

endmodule

### design/wave_equation_1d_stencil_step.sv
// Load: written in the beat it is accepted. Read: the bank read is registered, then the
// result is loaded and held until taken, and the input stalls while an older result is still waiting.
// Advance: N + 2 memory reads (one point per cycle through the bank read ports, plus the
// two wrap-around neighbors), then the four-stage stencil pipe drains; N = points in use.
// Reset: registers go to their defaults and bank a is present; banks undefined until loaded.
module wave_equation_1d_stencil_step import wes_pkg::*; #(
	parameter int MAX_POINTS  = DEF_MAX_POINTS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	wes_item_if.sink   item,
	wes_result_if.source result,
	wes_cfg_if.sink    cfg
);

	localparam int IW  = $clog2(MAX_POINTS);
	localparam int SW  = SAMPLE_BITS;
	localparam int KW  = $clog2(MAX_POINTS + 2);
	localparam int NXW = (KW > PTS_W) ? KW : PTS_W;

	state_t state_q, state_d;

	logic [PTS_W-1:0] pts_q;
	logic [CRS_W-1:0] c2_q;
	logic             sel_q;
	logic [KW-1:0]    k_q;
	logic [IW-1:0]    rd_idx_q;
	logic             res_v_q;
	logic [IW-1:0]    res_idx_q;
	logic [SW-1:0]    res_val_q;
	dp_ctl_t          ctl_s1;

	logic [NXW-1:0] pts_x, n_full;
	logic [KW-1:0]  n_eff, k_m1, k_m2, sweep_addr;
	logic           accept, idx_ok, last_k;
	kind_t          kind;
	logic           load_we, cur_re, past_re, res_load;
	logic [IW-1:0]  cur_addr, past_addr;

	logic [SW-1:0]  rdata_a, rdata_b;
	logic [SW-1:0]  cur_rdata, past_rdata;
	logic           we_a, we_b, re_a, re_b;
	logic [IW-1:0]  waddr, raddr_a, raddr_b;
	logic [SW-1:0]  wdata;

	logic           dp_wr_v, dp_busy;
	logic [IW-1:0]  dp_wr_idx;
	logic [SW-1:0]  dp_wr_data;

	always_comb begin
		pts_x = NXW'(pts_q);
		if (pts_x < NXW'(MIN_POINTS)) begin
			n_full = NXW'(MIN_POINTS);
		end else if (pts_x > NXW'(MAX_POINTS)) begin
			n_full = NXW'(MAX_POINTS);
		end else begin
			n_full = pts_x;
		end
		n_eff = n_full[KW-1:0];
	end

	assign kind   = kind_t'(item.kind);
	assign accept = item.valid & item.ready;
	assign idx_ok = KW'(item.point_index) < n_eff;
	assign k_m1   = k_q - KW'(1);
	assign k_m2   = k_q - KW'(2);
	assign last_k = k_q == n_eff + KW'(1);

	always_comb begin
		if (k_q == '0) begin
			sweep_addr = n_eff - KW'(1);
		end else if (last_k) begin
			sweep_addr = '0;
		end else begin
			sweep_addr = k_m1;
		end
	end

	assign cur_addr  = (state_q == ST_SWEEP) ? sweep_addr[IW-1:0] : item.point_index;
	assign past_addr = k_m2[IW-1:0];

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		load_we    = 1'b0;
		cur_re     = 1'b0;
		past_re    = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (accept) begin
					unique case (kind)
						KIND_LOAD: load_we = idx_ok;
						KIND_ADVANCE: state_d = ST_SWEEP;
						KIND_READ: begin
							if (idx_ok) begin
								cur_re  = 1'b1;
								state_d = ST_READ;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				if (!res_v_q || result.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cur_re  = 1'b1;
				past_re = k_q >= KW'(2);
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!ctl_s1.data_v && !dp_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q   <= PTS_RESET;
			c2_q    <= CRS_RESET;
			sel_q   <= 1'b0;
			k_q     <= '0;
			res_v_q <= 1'b0;
			ctl_s1  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (reg_idx_t'(cfg.index))
					REG_POINTS: pts_q <= cfg.data[PTS_W-1:0];
					REG_COURANT: c2_q <= cfg.data[CRS_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_SWEEP) begin
				k_q <= k_q + KW'(1);
			end else begin
				k_q <= '0;
			end
			if (state_q == ST_DRAIN && state_d == ST_IDLE) begin
				sel_q <= ~sel_q;
			end
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			ctl_s1.data_v   <= state_q == ST_SWEEP;
			ctl_s1.point_v  <= past_re;
			ctl_s1.first_pt <= past_re && k_q == KW'(2);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_idx_q <= item.point_index;
		end
		if (res_load) begin
			res_idx_q <= rd_idx_q;
			res_val_q <= cur_rdata;
		end
	end

	assign cfg.ready         = 1'b1;
	assign result.valid      = res_v_q;
	assign result.read_index = res_idx_q;
	assign result.read_value = res_val_q;

	// sel_q = 0: bank a present, bank b past
	assign we_a    = load_we | (dp_wr_v & sel_q);
	assign we_b    = load_we | (dp_wr_v & ~sel_q);
	assign waddr   = load_we ? item.point_index : dp_wr_idx;
	assign wdata   = load_we ? item.point_value : dp_wr_data;
	assign re_a    = sel_q ? past_re : cur_re;
	assign re_b    = sel_q ? cur_re : past_re;
	assign raddr_a = sel_q ? past_addr : cur_addr;
	assign raddr_b = sel_q ? cur_addr : past_addr;

	assign cur_rdata  = sel_q ? rdata_b : rdata_a;
	assign past_rdata = sel_q ? rdata_a : rdata_b;

	wes_field_mem #(
		.DEPTH(MAX_POINTS),
		.AW   (IW),
		.SW   (SW)
	) u_bank_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re_a),
		.raddr(raddr_a),
		.rdata(rdata_a)
	);

	wes_field_mem #(
		.DEPTH(MAX_POINTS),
		.AW   (IW),
		.SW   (SW)
	) u_bank_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re_b),
		.raddr(raddr_b),
		.rdata(rdata_b)
	);

	wes_stencil_dp #(
		.IW(IW),
		.SW(SW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s1),
		.c2        (c2_q),
		.cur_rdata ($signed(cur_rdata)),
		.past_rdata($signed(past_rdata)),
		.wr_v      (dp_wr_v),
		.wr_idx    (dp_wr_idx),
		.wr_data   (dp_wr_data),
		.busy      (dp_busy)
	);

	a_sel_flip_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DRAIN |=> sel_q == $past(sel_q))
		else $error("bank select changed outside the end of a step");

	a_wb_only_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		dp_wr_v |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("stencil write-back outside a step");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_we && dp_wr_v))
		else $error("load and write-back in the same cycle");

	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && state_d == ST_IDLE) |=> res_v_q)
		else $error("read finished without a result beat");

endmodule
